// ===== hdl/bsxch_pkg.sv =====
package bsxch_pkg;

    // field widths
    localparam int KIND_W  = 2;
    localparam int WORD_W  = 32;
    localparam int BIN_W   = 6;
    localparam int LAG_W   = 12;
    localparam int COUNT_W = 32;
    localparam int CH_W    = 5;
    localparam int CD_W    = 11;
    localparam int HW_W    = 5;

    // configuration port
    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = CD_W;

    // smallest internal lag width, enough for center plus window on both sides
    localparam int LAG_MIN_W = 13;

    // default sizing
    localparam int MAX_HALF_WIDTH_DEF = 31;
    localparam int HISTORY_DEPTH_DEF  = 1056;
    localparam int SKIP_WORDS_DEF     = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WORD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_A       = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_B       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_DISTANCE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
    } item_t;

    typedef struct packed {
        logic [BIN_W-1:0]        bin_index;
        logic signed [LAG_W-1:0] lag;
        logic [COUNT_W-1:0]      count;
        logic                    last_bin;
    } result_t;

    // control shared by every cell of the chain
    typedef struct packed {
        logic            step;
        logic            reload;
        logic            clear_hist;
        logic            dump_shift;
        logic            clear_count;
        logic            a_now;
        logic            b_now;
        logic [HW_W-1:0] width;
    } cell_ctl_t;

endpackage

// ===== hdl/bit_stream_cross_correlation_histogram.sv =====
// Time-difference correlation histogram of two bit channels of a 32-bit word stream.
// Item channel (item_valid/item_ready, item): kind word feeds one crossing, kind end
// closes the capture and clears the bit history, kind dump streams out the histogram
// and clears it. Kind words, end items and ignored kinds never hold item_ready low,
// so one item is accepted every cycle outside a dump or reload; the pair search is a
// chain of 2*MAX_HALF_WIDTH+1 cells that each compare the new bits with a delayed bit
// of the other channel. A dump holds item_ready low while its 2*half_width+1 bins
// leave the chain, one per cycle toward the output register; result_ready low
// stretches the dump by the stall. Result channel (result_valid/result_ready, result):
// first bin registered once the dump state is entered, last bin flagged by last_bin.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): after each write the
// chain reloads its window from the history memories, with item_ready low. cfg_ready
// is low during a dump.
// Reset clears the registers to their defaults, the histogram, the bit history and
// the word position; the history memories need no clearing pass.
module bit_stream_cross_correlation_histogram #(
    parameter int MAX_HALF_WIDTH = bsxch_pkg::MAX_HALF_WIDTH_DEF,
    parameter int HISTORY_DEPTH  = bsxch_pkg::HISTORY_DEPTH_DEF,
    parameter int SKIP_WORDS     = bsxch_pkg::SKIP_WORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  bsxch_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output bsxch_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsxch_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [bsxch_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NBINS = 2 * MAX_HALF_WIDTH + 1;
    localparam int CNT_W = $clog2(NBINS + 1);
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int KW    = PTR_W + 1;
    localparam int LW    = (PTR_W + 2 > bsxch_pkg::LAG_MIN_W) ? PTR_W + 2
                                                              : bsxch_pkg::LAG_MIN_W;
    localparam int BIN_W = bsxch_pkg::BIN_W;
    localparam int HW_W  = bsxch_pkg::HW_W;
    localparam int CD_W  = bsxch_pkg::CD_W;
    localparam int CH_W  = bsxch_pkg::CH_W;
    localparam int LAG_W = bsxch_pkg::LAG_W;

    localparam logic signed [LW-1:0] NBINS_S = LW'(NBINS);
    localparam logic signed [LW-1:0] ONE_S   = LW'(1);
    localparam logic [KW:0]          DEPTH_K = (KW + 1)'(HISTORY_DEPTH);
    localparam logic [HW_W-1:0]      MAX_HW  = HW_W'(MAX_HALF_WIDTH);

    typedef enum logic [1:0] {
        MODE_RUN,
        MODE_RELOAD,
        MODE_DUMP
    } mode_t;

    // configuration
    logic [CH_W-1:0]  channel_a_reg;
    logic [CH_W-1:0]  channel_b_reg;
    logic [CD_W-1:0]  center_reg;
    logic [HW_W-1:0]  half_width_reg;
    logic [HW_W-1:0]  w_eff;

    // control
    mode_t                state_reg;
    mode_t                state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [BIN_W-1:0]     idx_reg;
    logic [BIN_W-1:0]     idx_next;
    bsxch_pkg::result_t   result_reg;
    bsxch_pkg::result_t   result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    logic item_fire;
    logic cfg_fire;
    logic word_fire;
    logic end_fire;
    logic dump_fire;
    logic skip;
    logic step;
    logic load_out;
    logic last;
    logic reload_issue;
    logic reload_shift;
    logic a_now;
    logic b_now;

    // history bookkeeping
    logic [1:0]        word_pos_reg;
    logic [1:0]        word_pos_next;
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [KW-1:0]     fill_reg;
    logic [KW-1:0]     fill_next;

    // window feed from the history memories
    logic signed [LW-1:0] lag_base;
    logic signed [LW-1:0] w_ext;
    logic signed [LW-1:0] cnt_s;
    logic signed [LW-1:0] lag_a_iss;
    logic signed [LW-1:0] lag_b_iss;
    logic [PTR_W-1:0]     raddr_a;
    logic [PTR_W-1:0]     raddr_b;
    logic                 rd_a;
    logic                 rd_b;
    logic                 va_reg;
    logic                 va_next;
    logic                 vb_reg;
    logic                 vb_next;
    logic                 feed_a;
    logic                 feed_b;
    logic [LAG_W-1:0]     lag_out;

    bsxch_pkg::cell_ctl_t ctl;

    logic                          a_chain   [NBINS];
    logic                          b_chain   [NBINS];
    logic [bsxch_pkg::COUNT_W-1:0] cnt_chain [NBINS];

    function automatic logic lag_ok(input logic signed [LW-1:0] lag,
                                    input logic [KW-1:0] fill);
        logic [LW-1:0] mag;
        mag = $unsigned(lag);
        return !lag[LW-1] && (lag != '0) && (mag <= LW'(fill));
    endfunction

    // address of the bit written lag items before base
    function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                   input logic signed [LW-1:0] lag);
        logic [KW:0] diff;
        diff = {2'b00, base} + DEPTH_K - {1'b0, lag[KW-1:0]};
        if (diff >= DEPTH_K)
        begin
            diff = diff - DEPTH_K;
        end
        return diff[PTR_W-1:0];
    endfunction

    assign w_eff = (half_width_reg > MAX_HW) ? MAX_HW : half_width_reg;

    assign item_ready = (state_reg != MODE_DUMP) && (state_reg != MODE_RELOAD);
    assign cfg_ready  = (state_reg != MODE_DUMP);
    assign item_fire  = item_valid && item_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign word_fire  = item_fire && (item.kind == bsxch_pkg::KIND_WORD);
    assign end_fire   = item_fire && (item.kind == bsxch_pkg::KIND_END);
    assign dump_fire  = item_fire && (item.kind == bsxch_pkg::KIND_DUMP);
    assign skip       = (word_pos_reg < 2'(SKIP_WORDS));
    assign step       = word_fire && !skip;

    assign a_now = item.word[channel_a_reg];
    assign b_now = item.word[channel_b_reg];

    assign load_out = (state_reg == MODE_DUMP) && (!result_valid_reg || result_ready);
    assign last     = (idx_reg == {w_eff, 1'b0});

    assign reload_issue = (state_reg == MODE_RELOAD) && (cnt_reg < CNT_W'(NBINS));
    assign reload_shift = (state_reg == MODE_RELOAD) && (cnt_reg != '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_a_reg  <= CH_W'(0);
            channel_b_reg  <= CH_W'(1);
            center_reg     <= '0;
            half_width_reg <= HW_W'(1);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                bsxch_pkg::REG_CHANNEL_A:       channel_a_reg  <= cfg_data[CH_W-1:0];
                bsxch_pkg::REG_CHANNEL_B:       channel_b_reg  <= cfg_data[CH_W-1:0];
                bsxch_pkg::REG_CENTER_DISTANCE: center_reg     <= cfg_data[CD_W-1:0];
                bsxch_pkg::REG_HALF_WIDTH:      half_width_reg <= cfg_data[HW_W-1:0];
                default:                        ;
            endcase
        end
    end

    // word position, write pointer and fill level of the current capture
    always_comb
    begin
        word_pos_next = word_pos_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        if (end_fire)
        begin
            word_pos_next = 2'd0;
            fill_next     = '0;
        end
        else if (word_fire && skip)
        begin
            word_pos_next = word_pos_reg + 2'd1;
        end
        else if (step)
        begin
            wp_next   = (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            fill_next = (fill_reg == KW'(HISTORY_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        end
    end

    // lags of the next bits entering the chain ends, before this word shifts in
    assign w_ext    = {{(LW - HW_W){1'b0}}, w_eff};
    assign lag_base = $signed({{(LW - CD_W){center_reg[CD_W-1]}}, center_reg}) - w_ext;
    assign cnt_s    = {{(LW - CNT_W){1'b0}}, cnt_reg};

    always_comb
    begin
        if (reload_issue)
        begin
            lag_a_iss = lag_base + NBINS_S - ONE_S - cnt_s;
            lag_b_iss = -lag_base - cnt_s;
        end
        else
        begin
            lag_a_iss = lag_base - ONE_S;
            lag_b_iss = -lag_base - NBINS_S;
        end
    end

    assign raddr_a = ring_addr(wp_next, lag_a_iss);
    assign raddr_b = ring_addr(wp_next, lag_b_iss);
    assign va_next = lag_ok(lag_a_iss, fill_next);
    assign vb_next = lag_ok(lag_b_iss, fill_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg <= 2'd0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
        end
        else
        begin
            word_pos_reg <= word_pos_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            va_reg       <= va_next;
            vb_reg       <= vb_next;
        end
    end

    bsxch_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_a (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (wp_reg),
        .wr_bit  (a_now),
        .rd_addr (raddr_a),
        .rd_bit  (rd_a)
    );

    bsxch_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_b (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (wp_reg),
        .wr_bit  (b_now),
        .rd_addr (raddr_b),
        .rd_bit  (rd_b)
    );

    assign feed_a = rd_a && va_reg;
    assign feed_b = rd_b && vb_reg;

    always_comb
    begin
        ctl.step        = step;
        ctl.reload      = reload_shift;
        ctl.clear_hist  = end_fire;
        ctl.dump_shift  = load_out;
        ctl.clear_count = load_out && last;
        ctl.a_now       = a_now;
        ctl.b_now       = b_now;
        ctl.width       = w_eff;
    end

    // a bits travel up the chain, b bits down, counts down toward the output on a dump
    for (genvar j = 0; j < NBINS; j++)
    begin : g_cell
        logic                          a_in;
        logic                          b_in;
        logic [bsxch_pkg::COUNT_W-1:0] count_in;

        if (j == 0)
        begin : g_first
            assign a_in = feed_a;
        end
        else
        begin : g_inner_a
            assign a_in = a_chain[j-1];
        end

        if (j == NBINS - 1)
        begin : g_last
            assign b_in     = feed_b;
            assign count_in = '0;
        end
        else
        begin : g_inner_b
            assign b_in     = b_chain[j+1];
            assign count_in = cnt_chain[j+1];
        end

        bsxch_cell #(
            .LW            (LW),
            .HISTORY_DEPTH (HISTORY_DEPTH),
            .INDEX         (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .lag_base (lag_base),
            .a_in     (a_in),
            .b_in     (b_in),
            .count_in (count_in),
            .a_bit    (a_chain[j]),
            .b_bit    (b_chain[j]),
            .count    (cnt_chain[j])
        );
    end

    assign lag_out = {{(LAG_W - BIN_W){1'b0}}, idx_reg}
                   - {{(LAG_W - HW_W){1'b0}}, w_eff}
                   + {{(LAG_W - CD_W){center_reg[CD_W-1]}}, center_reg};

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            MODE_RUN:
            begin
                if (dump_fire)
                begin
                    state_next = MODE_DUMP;
                    idx_next   = '0;
                end
            end
            MODE_RELOAD:
            begin
                if (cnt_reg == CNT_W'(NBINS))
                begin
                    state_next = MODE_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_DUMP:
            begin
                if (load_out)
                begin
                    result_next.bin_index = idx_reg;
                    result_next.lag       = $signed(lag_out);
                    result_next.count     = cnt_chain[0];
                    result_next.last_bin  = last;
                    result_valid_next     = 1'b1;
                    if (last)
                    begin
                        state_next = MODE_RUN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = MODE_RUN;
            end
        endcase
        // any register write realigns the window
        if (cfg_fire)
        begin
            state_next = MODE_RELOAD;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= MODE_RUN;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            idx_reg          <= idx_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // fill level never passes the history depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= KW'(HISTORY_DEPTH))
        else $error("history fill level beyond depth");

    // the history write pointer holds while the window reloads
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MODE_RELOAD) |=> (wp_reg == $past(wp_reg)))
        else $error("history written during window reload");

    // an accepted dump transaction starts streaming bins
    assert property (@(posedge clk) disable iff (!rst_n)
        (dump_fire && !cfg_fire) |=> (state_reg == MODE_DUMP))
        else $error("dump transaction did not start a dump");

    // a bin leaves only while dumping
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(result_valid)) |-> ($past(state_reg) == MODE_DUMP))
        else $error("result produced outside a dump");

endmodule

// ===== hdl/bsxch_hist.sv =====
module bsxch_hist #(
    parameter int DEPTH = bsxch_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_bit,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_bit
);

    logic mem [DEPTH];
    logic rd_bit_reg;

    // a read of the address being written returns the new bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_bit_reg <= wr_bit;
        end
        else
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ===== hdl/bsxch_cell.sv =====
module bsxch_cell #(
    parameter int LW            = bsxch_pkg::LAG_MIN_W,
    parameter int HISTORY_DEPTH = bsxch_pkg::HISTORY_DEPTH_DEF,
    parameter int INDEX         = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bsxch_pkg::cell_ctl_t            ctl,
    input  logic signed [LW-1:0]            lag_base,
    input  logic                            a_in,
    input  logic                            b_in,
    input  logic [bsxch_pkg::COUNT_W-1:0]   count_in,
    output logic                            a_bit,
    output logic                            b_bit,
    output logic [bsxch_pkg::COUNT_W-1:0]   count
);

    localparam logic signed [LW-1:0] OFFSET    = LW'(INDEX);
    localparam logic signed [LW-1:0] DEPTH_S   = LW'(HISTORY_DEPTH);
    localparam logic signed [LW-1:0] NEG_DEPTH = -DEPTH_S;
    localparam logic signed [LW-1:0] LAG_ONE   = LW'(1);
    localparam logic signed [LW-1:0] LAG_MONE  = '1;
    localparam logic [bsxch_pkg::BIN_W:0] IDX_EXT = (bsxch_pkg::BIN_W + 1)'(INDEX);
    localparam bit HAS_BIN = (INDEX != 0);

    logic signed [LW-1:0]          lag;
    logic                          lag_zero;
    logic                          a_reach;
    logic                          b_reach;
    logic [bsxch_pkg::BIN_W:0]     two_w;
    logic                          active;
    logic                          hit;
    logic                          a_reg;
    logic                          a_next;
    logic                          b_reg;
    logic                          b_next;
    logic [bsxch_pkg::COUNT_W-1:0] count_reg;
    logic [bsxch_pkg::COUNT_W-1:0] count_next;

    // this cell watches pairs at lag tb - ta = lag
    assign lag      = lag_base + OFFSET;
    assign lag_zero = (lag == '0);
    assign a_reach  = !lag[LW-1] && !lag_zero && (lag <= DEPTH_S);
    assign b_reach  = lag[LW-1] && (lag >= NEG_DEPTH);
    assign two_w    = {1'b0, ctl.width, 1'b0};
    assign active   = HAS_BIN && (IDX_EXT < two_w);

    always_comb
    begin
        if (lag_zero)
        begin
            hit = active && ctl.a_now && ctl.b_now;
        end
        else
        begin
            hit = active && ((ctl.b_now && a_reg && a_reach) ||
                             (ctl.a_now && b_reg && b_reach));
        end
    end

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        count_next = count_reg;
        if (ctl.clear_hist)
        begin
            a_next = 1'b0;
            b_next = 1'b0;
        end
        else if (ctl.step)
        begin
            // a lag of one takes the bit of the word just seen
            a_next = (lag == LAG_ONE) ? ctl.a_now : a_in;
            b_next = (lag == LAG_MONE) ? ctl.b_now : b_in;
        end
        else if (ctl.reload)
        begin
            a_next = a_in;
            b_next = b_in;
        end

        if (ctl.clear_count)
        begin
            count_next = '0;
        end
        else if (ctl.dump_shift)
        begin
            count_next = count_in;
        end
        else if (ctl.step && hit && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= 1'b0;
            b_reg     <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            count_reg <= count_next;
        end
    end

    assign a_bit = a_reg;
    assign b_bit = b_reg;
    assign count = count_reg;

endmodule

// ===== test/bsxch_histogram_monitor.sv =====
module bsxch_histogram_monitor
    import bsxch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  item_t                item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   bins_pending
);

    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam int NBINS = 2 * MAX_HALF_WIDTH_DEF + 1;

    logic [CH_W-1:0]        sel_a;
    logic [CH_W-1:0]        sel_b;
    logic signed [CD_W-1:0] centre;
    logic [HW_W-1:0]        width;
    logic [DEPTH-1:0]       hist_a_bits;
    logic [DEPTH-1:0]       hist_b_bits;
    logic [COUNT_W-1:0]     bin_counts [0:NBINS-1];
    int                     words_skipped;
    result_t                bins_due [$];

    initial mismatches = 0;
    initial bins_pending = 0;

    // bit of k words ago, nothing beyond the stored history
    function automatic logic tapped(input logic [DEPTH-1:0] h, input int k);
        if (k < 1 || k > DEPTH)
            return 1'b0;
        return h[k-1];
    endfunction

    task automatic bump(input int bin);
        if (bin >= 0 && bin < NBINS && bin_counts[bin] != '1)
            bin_counts[bin] = bin_counts[bin] + 1'b1;
    endtask

    task automatic clear_counts();
        for (int i = 0; i < NBINS; i++)
            bin_counts[i] = '0;
    endtask

    task automatic absorb_word(input logic [WORD_W-1:0] w);
        logic a;
        logic b;
        int   c;
        int   hw;
        a  = w[sel_a];
        b  = w[sel_b];
        c  = int'(centre);
        hw = int'(width);
        for (int d = -(hw - 1); d <= hw - 1; d++)
        begin
            if (a && b && d == -c)
                bump(d + hw);
            if (a && tapped(hist_b_bits, -d - c))
                bump(d + hw);
            if (b && tapped(hist_a_bits, d + c))
                bump(d + hw);
        end
        hist_a_bits = {hist_a_bits[DEPTH-2:0], a};
        hist_b_bits = {hist_b_bits[DEPTH-2:0], b};
    endtask

    task automatic queue_dump();
        result_t r;
        int      hw;
        int      n;
        int      lag_v;
        hw = int'(width);
        n  = 2 * hw + 1;
        for (int i = 0; i < n; i++)
        begin
            lag_v       = i - hw + int'(centre);
            r.bin_index = i[BIN_W-1:0];
            r.lag       = lag_v[LAG_W-1:0];
            r.count     = bin_counts[i];
            r.last_bin  = (i == n - 1);
            bins_due.push_back(r);
        end
        clear_counts();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            sel_a         = '0;
            sel_b         = CH_W'(1);
            centre        = '0;
            width         = HW_W'(1);
            hist_a_bits   = '0;
            hist_b_bits   = '0;
            words_skipped = 0;
            clear_counts();
            bins_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CHANNEL_A:       sel_a  = cfg_data[CH_W-1:0];
                    REG_CHANNEL_B:       sel_b  = cfg_data[CH_W-1:0];
                    REG_CENTER_DISTANCE: centre = cfg_data[CD_W-1:0];
                    REG_HALF_WIDTH:      width  = cfg_data[HW_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (bins_due.size() == 0)
                begin
                    $error("unexpected result transaction, bin_index %0d", result.bin_index);
                    mismatches++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (result.bin_index !== want.bin_index)
                    begin
                        $error("bin_index expected %0d got %0d",
                               want.bin_index, result.bin_index);
                        mismatches++;
                    end
                    if (result.lag !== want.lag)
                    begin
                        $error("lag expected %0d got %0d",
                               $signed(want.lag), $signed(result.lag));
                        mismatches++;
                    end
                    if (result.count !== want.count)
                    begin
                        $error("count expected %0d got %0d", want.count, result.count);
                        mismatches++;
                    end
                    if (result.last_bin !== want.last_bin)
                    begin
                        $error("last_bin expected %0d got %0d",
                               want.last_bin, result.last_bin);
                        mismatches++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                case (item.kind)
                    KIND_WORD:
                    begin
                        if (words_skipped < SKIP_WORDS_DEF)
                            words_skipped++;
                        else
                            absorb_word(item.word);
                    end
                    KIND_END:
                    begin
                        hist_a_bits   = '0;
                        hist_b_bits   = '0;
                        words_skipped = 0;
                    end
                    KIND_DUMP: queue_dump();
                    default: ;
                endcase
            end
        end
        bins_pending = bins_due.size();
    end

endmodule

// ===== test/bit_stream_cross_correlation_histogram_tb.sv =====
module bit_stream_cross_correlation_histogram_tb;

    import bsxch_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    int mismatches;
    int bins_pending;

    bit items_calm      = 1'b0;
    bit results_brisk   = 1'b0;
    bit squeeze_pending = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bit_stream_cross_correlation_histogram i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bsxch_histogram_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .bins_pending (bins_pending)
    );

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random back-pressure, one long hold when asked
    initial
    begin
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            hold = results_brisk ? 0 : $urandom_range(0, 7);
            if (squeeze_pending)
            begin
                squeeze_pending = 1'b0;
                hold = 400;
            end
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // starts and ends at a falling edge, valid left high after the transaction
    task automatic offer_item(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] w);
        int gap;
        gap = items_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= {k, w};
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        wait (bins_pending == 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // unused upper data bits are filled with noise
    task automatic apply_setting(input int a, input int b, input int c, input int w);
        logic [CFG_W-1:0] v;
        v = $urandom;
        v[CH_W-1:0] = a[CH_W-1:0];
        write_reg(REG_CHANNEL_A, v);
        v = $urandom;
        v[CH_W-1:0] = b[CH_W-1:0];
        write_reg(REG_CHANNEL_B, v);
        write_reg(REG_CENTER_DISTANCE, c[CFG_W-1:0]);
        v = $urandom;
        v[HW_W-1:0] = w[HW_W-1:0];
        write_reg(REG_HALF_WIDTH, v);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_mix(input int quota);
        int sent;
        int len;
        int r;
        bit sparse;
        sent = 0;
        while (sent < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                len    = $urandom_range(4, 24);
                sparse = $urandom_range(0, 1);
                for (int j = 0; j < len; j++)
                    offer_item(KIND_WORD, sparse ? ($urandom & $urandom) : $urandom);
                sent += len;
                if ($urandom_range(0, 7) != 0)
                begin
                    offer_item(KIND_END, $urandom);
                    sent++;
                end
            end
            else if (r < 85)
            begin
                offer_item(KIND_DUMP, $urandom);
                sent++;
            end
            else if (r < 93)
                offer_item(KIND_SPARE, $urandom);
            else
            begin
                // capture broken off, possibly inside the skipped words
                offer_item(KIND_END, $urandom);
                sent++;
            end
        end
        offer_item(KIND_DUMP, $urandom);
    endtask

    initial
    begin
        int a;
        int b;
        int c;
        int w;
        wait (rst_n);
        @(negedge clk);

        // reset defaults: channels 0 and 1, no offset, half width 1
        offer_item(KIND_DUMP, 32'h0);
        repeat (3) offer_item(KIND_WORD, 32'hFFFF_FFFF);
        offer_item(KIND_WORD, 32'h0000_0003);
        offer_item(KIND_WORD, 32'h0000_0001);
        offer_item(KIND_WORD, 32'h0000_0002);
        offer_item(KIND_WORD, 32'hFFFF_FFFF);
        offer_item(KIND_WORD, 32'h0000_0000);
        offer_item(KIND_SPARE, 32'hFFFF_FFFF);
        offer_item(KIND_END, 32'hFFFF_FFFF);
        offer_item(KIND_WORD, 32'hFFFF_FFFF);
        offer_item(KIND_DUMP, 32'hFFFF_FFFF);
        drain();

        // same channel on both sides, each hit pairs with itself
        apply_setting(31, 31, -2, 4);
        repeat (3) offer_item(KIND_WORD, 32'h8000_0000);
        offer_item(KIND_WORD, 32'h8000_0000);
        offer_item(KIND_WORD, 32'h7FFF_FFFF);
        offer_item(KIND_WORD, 32'h8000_0000);
        offer_item(KIND_DUMP, 32'h0);
        drain();

        // zero half width gives a single empty bin
        apply_setting(5, 20, 7, 0);
        repeat (4) offer_item(KIND_WORD, 32'hFFFF_FFFF);
        offer_item(KIND_DUMP, 32'h0);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            a = (ph == 0) ? 0 : (ph == 1) ? 31 : $urandom_range(0, 31);
            b = (ph == 0) ? 31 : (ph == 1) ? 0 : $urandom_range(0, 31);
            if (ph == 4)
                b = a;
            c = (ph == 2) ? 1023 : (ph == 6) ? -1023 : $urandom_range(0, 60) - 30;
            w = (ph % 4 == 0) ? 31 : (ph == 3) ? 0 : $urandom_range(1, 31);
            apply_setting(a, b, c, w);
            items_calm    = (ph % 3 == 1);
            results_brisk = (ph % 4 == 2);
            if (ph == 5)
            begin
                squeeze_pending = 1'b1;
                offer_item(KIND_DUMP, $urandom);
            end
            run_mix(20);
            drain();
        end

        // one capture long enough to reach every lag of a full window
        items_calm    = 1'b0;
        results_brisk = 1'b0;
        apply_setting($urandom_range(0, 31), $urandom_range(0, 31), -30, 31);
        for (int j = 0; j < 64; j++)
            offer_item(KIND_WORD, $urandom & $urandom & $urandom);
        offer_item(KIND_END, $urandom);
        offer_item(KIND_DUMP, $urandom);
        drain();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
